/* rtl/core/cldd_pkg.sv */
// ----------------------------------------------------------------------------
// cldd_pkg
// Shared types, widths and constants of the capacitive lawn drop detector.
// ----------------------------------------------------------------------------
package cldd_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int LEVEL_W    = 32;
    localparam int GAIN_W     = 16;
    localparam int PCT_W      = 7;
    localparam int DCNT_W     = 16;

    localparam int PCT_SCALE  = 100;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd1966;
    localparam logic [PCT_W-1:0]  PCT_RESET  = 7'd95;

    // Configuration port.
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int REG_SEL_BIT = 2;

    // Stream widths.
    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 2;
    localparam int OUT_W     = 3 + 2 * LEVEL_W + DCNT_W + 1;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Result field positions inside m_tdata.
    localparam int SEND_FRONT_BIT = 0;
    localparam int SEND_BACK_BIT  = 1;
    localparam int BUSY_BIT       = 2;
    localparam int FRONT_LSB      = 3;
    localparam int BACK_LSB       = FRONT_LSB + LEVEL_W;
    localparam int DCNT_LSB       = BACK_LSB + LEVEL_W;
    localparam int DETECTED_BIT   = DCNT_LSB + DCNT_W;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_CHECK = 2'd2,
        OP_NOP   = 2'd3
    } cldd_op_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_FRONT = 3'b010,
        PH_BACK  = 3'b100
    } cldd_phase_t;

    typedef enum logic {
        REG_GAIN = 1'b0,
        REG_PCT  = 1'b1
    } cldd_reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain;
        logic [PCT_W-1:0]  pct;
    } cldd_cfg_t;

    typedef struct packed {
        cldd_op_t opcode;
        logic     rx_front;
        logic     rx_back;
    } cldd_item_t;

endpackage

/* rtl/core/cldd_cfg_regs.sv */
// ----------------------------------------------------------------------------
// cldd_cfg_regs
// APB register file holding the smoothing gain and the drop percentage.
// ----------------------------------------------------------------------------
module cldd_cfg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cldd_pkg::APB_AW-1:0]   paddr,
    input  logic [cldd_pkg::APB_DW-1:0]   pwdata,
    output logic [cldd_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output cldd_pkg::cldd_cfg_t           cfg
);
    import cldd_pkg::*;

    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] gain_next;
    logic [PCT_W-1:0]  pct_reg;
    logic [PCT_W-1:0]  pct_next;
    logic              wr_en;
    cldd_reg_idx_t     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = cldd_reg_idx_t'(paddr[REG_SEL_BIT]);

    always_comb
    begin
        gain_next = gain_reg;
        pct_next  = pct_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_GAIN: gain_next = pwdata[GAIN_W-1:0];
                REG_PCT:  pct_next  = pwdata[PCT_W-1:0];
                default:  gain_next = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
            pct_reg  <= PCT_RESET;
        end
        else
        begin
            gain_reg <= gain_next;
            pct_reg  <= pct_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN: prdata = APB_DW'(gain_reg);
            REG_PCT:  prdata = APB_DW'(pct_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.gain = gain_reg;
    assign cfg.pct  = pct_reg;

endmodule

/* rtl/core/cldd_in_stage.sv */
// ----------------------------------------------------------------------------
// cldd_in_stage
// Input register: captures one item and holds it until the core takes it.
// ----------------------------------------------------------------------------
module cldd_in_stage
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cldd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [cldd_pkg::S_TUSER_W-1:0]  s_tuser,
    input  logic                            advance,
    output logic                            item_valid,
    output cldd_pkg::cldd_item_t            item
);
    import cldd_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    cldd_item_t item_reg;
    logic       accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode   <= cldd_op_t'(s_tuser);
            item_reg.rx_front <= s_tdata[0];
            item_reg.rx_back  <= s_tdata[1];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* rtl/core/cldd_smooth.sv */
// ----------------------------------------------------------------------------
// cldd_smooth
// Exponential average of a charge-time count into a Q16.16 level.
// ----------------------------------------------------------------------------
module cldd_smooth
(
    input  logic [cldd_pkg::GAIN_W-1:0]     gain,
    input  logic [cldd_pkg::LEVEL_W-1:0]    avg,
    input  logic [cldd_pkg::COUNT_BITS-1:0] ticks,
    output logic [cldd_pkg::LEVEL_W-1:0]    level
);
    import cldd_pkg::*;

    localparam int SAMPLE_W = COUNT_BITS + FRAC_BITS;
    localparam int SAT_W    = (SAMPLE_W > LEVEL_W) ? SAMPLE_W : LEVEL_W;
    localparam int OLD_W    = GAIN_W + 1 + LEVEL_W;
    localparam int NEW_W    = GAIN_W + LEVEL_W;
    localparam int ACC_W    = OLD_W + 1;

    logic [SAMPLE_W-1:0] sample_wide;
    logic [SAT_W-1:0]    sample_ext;
    logic [LEVEL_W-1:0]  sample;
    logic [GAIN_W:0]     keep;
    logic [OLD_W-1:0]    prod_old;
    logic [NEW_W-1:0]    prod_new;
    logic [ACC_W-1:0]    acc;

    assign sample_wide = {ticks, {FRAC_BITS{1'b0}}};
    assign sample_ext  = SAT_W'(sample_wide);

    // A count shifted past the level width saturates at full scale.
    assign sample = (sample_ext > SAT_W'({LEVEL_W{1'b1}})) ? {LEVEL_W{1'b1}}
                                                           : sample_ext[LEVEL_W-1:0];

    assign keep     = {1'b1, {GAIN_W{1'b0}}} - {1'b0, gain};
    assign prod_old = keep * avg;
    assign prod_new = gain * sample;

    // Round to nearest, ties up, before dropping the gain fraction.
    assign acc = ACC_W'(prod_old) + ACC_W'(prod_new)
               + ACC_W'({1'b1, {(GAIN_W-1){1'b0}}});

    assign level = acc[GAIN_W +: LEVEL_W];

endmodule

/* rtl/core/cldd_drop_check.sv */
// ----------------------------------------------------------------------------
// cldd_drop_check
// Compares a level against a percentage of its previous value.
// ----------------------------------------------------------------------------
module cldd_drop_check
(
    input  logic [cldd_pkg::LEVEL_W-1:0] level,
    input  logic [cldd_pkg::LEVEL_W-1:0] prev,
    input  logic [cldd_pkg::PCT_W-1:0]   pct,
    output logic                         dropped
);
    import cldd_pkg::*;

    localparam int PROD_W = LEVEL_W + PCT_W;

    logic [PROD_W-1:0] scaled_level;
    logic [PROD_W-1:0] scaled_prev;

    assign scaled_level = PROD_W'(level) * PROD_W'(PCT_SCALE);
    assign scaled_prev  = PROD_W'(prev) * PROD_W'(pct);

    // A channel with no previous level never reports a drop.
    assign dropped = (prev != '0) && (scaled_level <= scaled_prev);

endmodule

/* rtl/core/capacitive_lawn_drop_detector_core.sv */
// ----------------------------------------------------------------------------
// capacitive_lawn_drop_detector_core
// Two-channel charge-time capacitive sensor with smoothed levels and
// drop detection.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// s_*       in         s_tvalid/s_tready  tuser: opcode; tdata: rx_front, rx_back
// m_*       out        m_tvalid/m_tready  tdata: sends, busy, levels, count, flag
// APB       in/out     psel/penable       gain at 0x0, drop percent at 0x4
//
// One item per cycle is sustained while m_tready stays high.
// An accepted item is first captured in the input register, then its result
// is loaded into the output register.
// The averaging multipliers and drop compares run between these registers.
// rst_n clears all sensor state and loads the register defaults at once.
// A stalled output holds its result; one further item waits in the input
// register and s_tready then stays low until m_tready returns.
// ----------------------------------------------------------------------------
module capacitive_lawn_drop_detector_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] rx_front, [1] rx_back, [7:2] zero
    input  logic [cldd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [cldd_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] send_front, [1] send_back, [2] busy_res, [34:3] front_level,
    // [66:35] back_level, [82:67] detection_count, [83] lawn_detected, [87:84] zero
    output logic [cldd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cldd_pkg::APB_AW-1:0]     paddr,
    input  logic [cldd_pkg::APB_DW-1:0]     pwdata,
    output logic [cldd_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);
    import cldd_pkg::*;

    cldd_cfg_t   cfg;
    cldd_item_t  item;
    logic        item_valid;
    logic        advance;

    cldd_phase_t         phase_reg,      phase_next;
    logic [COUNT_BITS-1:0] tick_reg,     tick_next;
    logic [LEVEL_W-1:0]  front_avg_reg,  front_avg_next;
    logic [LEVEL_W-1:0]  back_avg_reg,   back_avg_next;
    logic [LEVEL_W-1:0]  front_prev_reg, front_prev_next;
    logic [LEVEL_W-1:0]  back_prev_reg,  back_prev_next;
    logic [DCNT_W-1:0]   dcnt_reg,       dcnt_next;
    logic                sticky_reg,     sticky_next;

    logic                m_tvalid_reg,   m_tvalid_next;
    logic [OUT_W-1:0]    res_reg,        res_next;

    logic [LEVEL_W-1:0]    avg_sel;
    logic [LEVEL_W-1:0]    smoothed;
    logic [COUNT_BITS-1:0] tick_inc;
    logic                  front_drop;
    logic                  back_drop;

    cldd_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cldd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Only the channel being measured is averaged, so one unit serves both.
    assign avg_sel = (phase_reg == PH_FRONT) ? front_avg_reg : back_avg_reg;

    cldd_smooth u_smooth
    (
        .gain  (cfg.gain),
        .avg   (avg_sel),
        .ticks (tick_reg),
        .level (smoothed)
    );

    cldd_drop_check u_front_check
    (
        .level   (front_avg_reg),
        .prev    (front_prev_reg),
        .pct     (cfg.pct),
        .dropped (front_drop)
    );

    cldd_drop_check u_back_check
    (
        .level   (back_avg_reg),
        .prev    (back_prev_reg),
        .pct     (cfg.pct),
        .dropped (back_drop)
    );

    assign advance  = item_valid && (!m_tvalid_reg || m_tready);
    assign tick_inc = (tick_reg != {COUNT_BITS{1'b1}}) ? tick_reg + 1'b1 : tick_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        front_avg_next  = front_avg_reg;
        back_avg_next   = back_avg_reg;
        front_prev_next = front_prev_reg;
        back_prev_next  = back_prev_reg;
        dcnt_next       = dcnt_reg;
        sticky_next     = sticky_reg;

        if (advance)
        begin
            unique case (item.opcode)
                OP_TICK:
                begin
                    unique case (phase_reg)
                        PH_FRONT:
                        begin
                            if (item.rx_front)
                            begin
                                front_avg_next = smoothed;
                                tick_next      = '0;
                                phase_next     = PH_BACK;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        PH_BACK:
                        begin
                            if (item.rx_back)
                            begin
                                back_avg_next = smoothed;
                                tick_next     = '0;
                                phase_next    = PH_IDLE;
                            end
                            else
                            begin
                                tick_next = tick_inc;
                            end
                        end
                        PH_IDLE:
                        begin
                            phase_next = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                OP_START:
                begin
                    if (phase_reg != PH_FRONT && phase_reg != PH_BACK)
                    begin
                        phase_next = PH_FRONT;
                        tick_next  = '0;
                    end
                end
                OP_CHECK:
                begin
                    if (front_drop || back_drop)
                    begin
                        if (dcnt_reg != {DCNT_W{1'b1}})
                        begin
                            dcnt_next = dcnt_reg + 1'b1;
                        end
                        sticky_next = 1'b1;
                    end
                    front_prev_next = front_avg_reg;
                    back_prev_next  = back_avg_reg;
                end
                OP_NOP:
                begin
                    phase_next = phase_reg;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // The result shows the state as the item leaves it.
    assign res_next = {sticky_next, dcnt_next, back_avg_next, front_avg_next,
                       (phase_next == PH_FRONT) || (phase_next == PH_BACK),
                       phase_next == PH_BACK, phase_next == PH_FRONT};

    always_comb
    begin
        if (advance)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            front_avg_reg  <= '0;
            back_avg_reg   <= '0;
            front_prev_reg <= '0;
            back_prev_reg  <= '0;
            dcnt_reg       <= '0;
            sticky_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            front_avg_reg  <= front_avg_next;
            back_avg_reg   <= back_avg_next;
            front_prev_reg <= front_prev_next;
            back_prev_reg  <= back_prev_next;
            dcnt_reg       <= dcnt_next;
            sticky_reg     <= sticky_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - OUT_W){1'b0}}, res_reg};

endmodule

/* rtl/core/cldd_checker.sv */
// ----------------------------------------------------------------------------
// cldd_checker
// Port-level assertions for the capacitive lawn drop detector core.
// ----------------------------------------------------------------------------
module cldd_checker
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [cldd_pkg::M_TDATA_W-1:0] m_tdata
);
    import cldd_pkg::*;

    // A held result must not change while the sink stalls.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed or vanished while stalled");

    // Only one channel is ever driven at a time.
    a_one_send: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[SEND_FRONT_BIT] && m_tdata[SEND_BACK_BIT]))
        else $error("both send lines driven");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[BUSY_BIT] ==
                      (m_tdata[SEND_FRONT_BIT] || m_tdata[SEND_BACK_BIT])))
        else $error("busy disagrees with send lines");

    // The sticky flag is set exactly when at least one drop was counted.
    a_flag_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[DETECTED_BIT] ==
                      (m_tdata[DCNT_LSB +: DCNT_W] != '0)))
        else $error("detected flag disagrees with detection count");

    // The input side only stalls behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

endmodule

bind capacitive_lawn_drop_detector_core cldd_checker u_cldd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
